// File: hdl/b58enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b58enc_pkg
// Shared constants, types and the alphabet lookup for the base-58 encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

  localparam int MAX_IN_BYTES = 32;
  localparam int OUT_DIGITS   = 45;
  localparam int MAX_RESULTS  = 45;

  localparam int DIGIT_W = 6;
  localparam int IDX_W   = $clog2(OUT_DIGITS);
  localparam int CNT_W   = 6;
  localparam int CARRY_W = 8;
  localparam int SUM_W   = DIGIT_W + 8;
  localparam int SYM_W   = 7;
  localparam int TOT_W   = 8;

  // floor(x / 58) == (x * RECIP_58) >> RECIP_SHIFT for every x below 2**SUM_W.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_58    = (2 ** RECIP_SHIFT + 57) / 58;
  localparam int RECIP_W     = 15;

  localparam logic [SYM_W-1:0] SYM_ZERO = SYM_W'(8'h72);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_CHECK,
    S_ZEROS,
    S_DIG_RD,
    S_DIG_PUT
  } state_t;

  function automatic logic [SYM_W-1:0] alphabet(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    unique case (d)
      6'd0:  c = "r";  6'd1:  c = "p";  6'd2:  c = "s";  6'd3:  c = "h";
      6'd4:  c = "n";  6'd5:  c = "a";  6'd6:  c = "f";  6'd7:  c = "3";
      6'd8:  c = "9";  6'd9:  c = "w";  6'd10: c = "B";  6'd11: c = "U";
      6'd12: c = "D";  6'd13: c = "N";  6'd14: c = "E";  6'd15: c = "G";
      6'd16: c = "H";  6'd17: c = "J";  6'd18: c = "K";  6'd19: c = "L";
      6'd20: c = "M";  6'd21: c = "4";  6'd22: c = "P";  6'd23: c = "Q";
      6'd24: c = "R";  6'd25: c = "S";  6'd26: c = "T";  6'd27: c = "7";
      6'd28: c = "V";  6'd29: c = "W";  6'd30: c = "X";  6'd31: c = "Y";
      6'd32: c = "Z";  6'd33: c = "2";  6'd34: c = "b";  6'd35: c = "c";
      6'd36: c = "d";  6'd37: c = "e";  6'd38: c = "C";  6'd39: c = "g";
      6'd40: c = "6";  6'd41: c = "5";  6'd42: c = "j";  6'd43: c = "k";
      6'd44: c = "m";  6'd45: c = "8";  6'd46: c = "o";  6'd47: c = "F";
      6'd48: c = "q";  6'd49: c = "i";  6'd50: c = "1";  6'd51: c = "t";
      6'd52: c = "u";  6'd53: c = "v";  6'd54: c = "A";  6'd55: c = "x";
      6'd56: c = "y";  6'd57: c = "z";
      default: c = 8'h00;
    endcase
    return c[SYM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/base58_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base58_encoder
// Streaming base-58 encoder with the ripple alphabet.
// ----------------------------------------------------------------------------
// Bytes of a message arrive most significant first, the final byte marked by
// tlast, and the base-58 text leaves as one character per transfer, the final
// one marked by tlast; tuser high flags an error transfer (input over 32 bytes
// or text longer than max_out_len or 45 characters) whose character is zero.
// A leading zero byte, a byte past the limit or a byte after an overflow is
// taken without a fold. Every other byte ripples the whole 45-digit store once
// through a single divide-by-58 unit, one digit per cycle, with one read and
// one write of the digit store in each cycle, and the input is not ready
// again until the fold is through. After the final byte it checks the length,
// sends one 'r' per leading zero byte, then for each further character reads
// the store, then loads the output register; the output side can stall it.
// ----------------------------------------------------------------------------
module base58_encoder
  import b58enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,      // max_out_len

  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  wire logic       s_axis_tlast,   // last_byte

  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] symbol, [7] zero
  output logic            m_axis_tlast,   // last_symbol
  output logic            m_axis_tuser    // overflow
);

  state_t state, state_next;

  logic [7:0]         max_out_len;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [CARRY_W-1:0] carry, carry_next;
  logic               last_pend, last_pend_next;
  logic [CNT_W-1:0]   lzc, lzc_next;
  logic               nz_seen, nz_seen_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic               too_long, too_long_next;
  logic [IDX_W-1:0]   first, first_next;
  logic [CNT_W-1:0]   zcnt, zcnt_next;

  logic [DIGIT_W-1:0] mem [OUT_DIGITS];
  logic [OUT_DIGITS-1:0] valid;
  logic [IDX_W-1:0]   rd_addr;
  logic [DIGIT_W-1:0] rd_data;
  logic               rd_vld;
  logic [DIGIT_W-1:0] digit_eff;
  logic               mem_we;

  logic [DIGIT_W-1:0] step_digit;
  logic [CARRY_W-1:0] step_carry;

  logic               out_free;
  logic               load_out;
  logic [SYM_W-1:0]   out_sym;
  logic               out_last;
  logic               out_ovf;
  logic               clear;

  logic [TOT_W-1:0]   sig;
  logic [TOT_W-1:0]   total;
  logic               err;
  logic [CNT_W-1:0]   zcnt_inc;

  assign digit_eff = rd_vld ? rd_data : '0;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  assign sig   = TOT_W'(OUT_DIGITS) - TOT_W'(first);
  assign total = TOT_W'(lzc) + sig;
  assign err   = too_long || (total > max_out_len) || (total > TOT_W'(MAX_RESULTS))
                 || (total == '0);
  assign zcnt_inc = zcnt + CNT_W'(1);

  b58enc_digit_step u_step (
    .digit     (digit_eff),
    .carry_in  (carry),
    .digit_out (step_digit),
    .carry_out (step_carry)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= step_digit;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        valid[idx] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_out_len <= 8'hFF;
      idx         <= '0;
      carry       <= '0;
      last_pend   <= 1'b0;
      lzc         <= '0;
      nz_seen     <= 1'b0;
      byte_count  <= '0;
      too_long    <= 1'b0;
      first       <= IDX_W'(OUT_DIGITS);
      zcnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      carry      <= carry_next;
      last_pend  <= last_pend_next;
      lzc        <= lzc_next;
      nz_seen    <= nz_seen_next;
      byte_count <= byte_count_next;
      too_long   <= too_long_next;
      first      <= first_next;
      zcnt       <= zcnt_next;
      if (cfg_we) begin
        max_out_len <= cfg_wdata;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {1'b0, out_sym};
      m_axis_tlast <= out_last;
      m_axis_tuser <= out_ovf;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    carry_next      = carry;
    last_pend_next  = last_pend;
    lzc_next        = lzc;
    nz_seen_next    = nz_seen;
    byte_count_next = byte_count;
    too_long_next   = too_long;
    first_next      = first;
    zcnt_next       = zcnt;
    rd_addr         = idx;
    mem_we          = 1'b0;
    load_out        = 1'b0;
    out_sym         = '0;
    out_last        = 1'b0;
    out_ovf         = 1'b0;
    clear           = 1'b0;

    unique case (state)
      S_IDLE: begin
        rd_addr = IDX_W'(OUT_DIGITS - 1);
        if (s_axis_tvalid) begin
          last_pend_next = s_axis_tlast;
          state_next     = s_axis_tlast ? S_CHECK : S_IDLE;
          if (byte_count >= CNT_W'(MAX_IN_BYTES)) begin
            too_long_next = 1'b1;
          end else begin
            byte_count_next = byte_count + CNT_W'(1);
            if (!too_long) begin
              if (!nz_seen && (s_axis_tdata == 8'h00)) begin
                lzc_next = lzc + CNT_W'(1);
              end else begin
                nz_seen_next = 1'b1;
                carry_next   = s_axis_tdata;
                idx_next     = IDX_W'(OUT_DIGITS - 1);
                state_next   = S_FOLD;
              end
            end
          end
        end
      end

      S_FOLD: begin
        mem_we     = 1'b1;
        rd_addr    = (idx == '0) ? idx : idx - IDX_W'(1);
        carry_next = step_carry;
        if ((step_digit != '0) && (idx < first)) begin
          first_next = idx;
        end
        if (idx == '0) begin
          if (step_carry != '0) begin
            too_long_next = 1'b1;
          end
          state_next = last_pend ? S_CHECK : S_IDLE;
        end else begin
          idx_next = idx - IDX_W'(1);
        end
      end

      S_CHECK: begin
        if (err) begin
          if (out_free) begin
            load_out = 1'b1;
            out_last = 1'b1;
            out_ovf  = 1'b1;
            clear    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          zcnt_next  = '0;
          idx_next   = first;
          state_next = (lzc != '0) ? S_ZEROS : S_DIG_RD;
        end
      end

      S_ZEROS: begin
        if (out_free) begin
          load_out  = 1'b1;
          out_sym   = SYM_ZERO;
          out_last  = (zcnt_inc == lzc) && (first == IDX_W'(OUT_DIGITS));
          zcnt_next = zcnt_inc;
          if (zcnt_inc == lzc) begin
            if (first == IDX_W'(OUT_DIGITS)) begin
              clear      = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_DIG_RD;
            end
          end
        end
      end

      S_DIG_RD: begin
        state_next = S_DIG_PUT;
      end

      S_DIG_PUT: begin
        if (out_free) begin
          load_out = 1'b1;
          out_sym  = alphabet(digit_eff);
          out_last = (idx == IDX_W'(OUT_DIGITS - 1));
          if (idx == IDX_W'(OUT_DIGITS - 1)) begin
            clear      = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_DIG_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (clear) begin
      lzc_next        = '0;
      nz_seen_next    = 1'b0;
      byte_count_next = '0;
      too_long_next   = 1'b0;
      first_next      = IDX_W'(OUT_DIGITS);
      last_pend_next  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/b58enc_digit_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b58enc_digit_step
// One carry step of the fold: (digit * 256 + carry) split into a new base-58
// digit and the carry into the next more significant digit.
// ----------------------------------------------------------------------------
module b58enc_digit_step
  import b58enc_pkg::*;
(
  input  wire logic [DIGIT_W-1:0] digit,
  input  wire logic [CARRY_W-1:0] carry_in,
  output logic      [DIGIT_W-1:0] digit_out,
  output logic      [CARRY_W-1:0] carry_out
);

  logic [SUM_W-1:0]             sum;
  logic [SUM_W+RECIP_W-1:0]     prod;
  logic [CARRY_W-1:0]           quot;
  logic [SUM_W-1:0]             quot_x58;
  logic [SUM_W-1:0]             rem;

  assign sum  = {digit, 8'h00} + SUM_W'(carry_in);
  assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_58);
  assign quot = prod[RECIP_SHIFT +: CARRY_W];

  // 58 * q = 64 * q - 4 * q - 2 * q
  assign quot_x58 = {quot, 6'b0} - SUM_W'({quot, 2'b0}) - SUM_W'({quot, 1'b0});
  assign rem      = sum - quot_x58;

  assign digit_out = rem[DIGIT_W-1:0];
  assign carry_out = quot;

endmodule
`default_nettype wire
